// ----- src/dbcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcw_pkg
// Shared types, codes and parameter defaults of the delay-based congestion window.
// ----------------------------------------------------------------------------
package dbcw_pkg;

    localparam int unsigned TIMEOUT_MULT_DEF         = 2;
    localparam int unsigned PROCESS_DELAY_US_DEF     = 1000;
    localparam int unsigned IDLE_TIMEOUT_STEP_US_DEF = 1000000;

    localparam logic [2:0] CFG_SMOOTH_LONG  = 3'd0;
    localparam logic [2:0] CFG_SMOOTH_SHORT = 3'd1;
    localparam logic [2:0] CFG_ALPHA        = 3'd2;
    localparam logic [2:0] CFG_BETA         = 3'd3;
    localparam logic [2:0] CFG_INCREMENT    = 3'd4;
    localparam logic [2:0] CFG_BASE         = 3'd5;
    localparam logic [2:0] CFG_SS_THRESH    = 3'd6;
    localparam logic [2:0] CFG_MAX_WINDOW   = 3'd7;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_OUTDATED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIMEOUT,
        S_SMOOTH_LONG,
        S_SMOOTH_SHORT,
        S_LOSS_DIV,
        S_RATIO_DIV,
        S_STEP_DIV,
        S_WINDOW,
        S_OUT,
        S_HOLD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic do_timeout;
        logic do_drop;
        logic do_unknown;
        logic smooth_long;
        logic smooth_short;
        logic div_start;
        logic [1:0] div_sel;
        logic do_window;
        logic do_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_timeout;
        logic is_old;
        logic is_known;
        logic div_busy;
        logic total_zero;
        logic slow_start;
        logic short_zero;
    } t_status;

    localparam logic [1:0] DIV_LOSS  = 2'd0;
    localparam logic [1:0] DIV_RATIO = 2'd1;
    localparam logic [1:0] DIV_STEP  = 2'd2;

endpackage

// ----- src/dbcw_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbcw_div
// Restoring divider, 48-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module dbcw_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [47:0]      o_quot
);

    logic [47:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_shift;
    logic [32:0] n_diff;

    assign n_shift = {r_rem[31:0], r_q[47]};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd48;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!n_diff[32]) begin
                r_rem <= n_diff;
                r_q   <= {r_q[46:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_q   <= {r_q[46:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ----- src/dbcw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbcw_ctrl
// Event sequencer: steps one event through timeout check, smoothing, divisions, update and output.
// ----------------------------------------------------------------------------
module dbcw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    input  wire dbcw_pkg::t_status  i_status,
    output dbcw_pkg::t_cmd          o_cmd
);

    dbcw_pkg::t_state r_state, n_state;
    logic             r_div_go;
    logic             n_div_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dbcw_pkg::S_IDLE;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_div_go = 1'b0;
        o_cmd    = '0;
        o_stall  = 1'b1;
        o_valid  = 1'b0;
        case (r_state)
            dbcw_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dbcw_pkg::S_TIMEOUT;
                end
            end
            dbcw_pkg::S_TIMEOUT: begin
                if (i_status.is_timeout) begin
                    o_cmd.do_timeout = 1'b1;
                    n_state          = dbcw_pkg::S_OUT;
                end else if (i_status.is_old) begin
                    o_cmd.do_drop = 1'b1;
                    n_state       = dbcw_pkg::S_OUT;
                end else if (!i_status.is_known) begin
                    o_cmd.do_unknown = 1'b1;
                    n_state          = dbcw_pkg::S_OUT;
                end else begin
                    n_state = dbcw_pkg::S_SMOOTH_LONG;
                end
            end
            dbcw_pkg::S_SMOOTH_LONG: begin
                o_cmd.smooth_long = 1'b1;
                n_state           = dbcw_pkg::S_SMOOTH_SHORT;
            end
            dbcw_pkg::S_SMOOTH_SHORT: begin
                o_cmd.smooth_short = 1'b1;
                o_cmd.div_sel      = dbcw_pkg::DIV_LOSS;
                o_cmd.div_start    = !i_status.total_zero;
                n_div_go           = !i_status.total_zero;
                n_state            = dbcw_pkg::S_LOSS_DIV;
            end
            dbcw_pkg::S_LOSS_DIV: begin
                o_cmd.div_sel = dbcw_pkg::DIV_LOSS;
                if (!i_status.div_busy && !r_div_go) begin
                    if (i_status.slow_start) begin
                        n_state = dbcw_pkg::S_WINDOW;
                    end else begin
                        o_cmd.div_sel   = dbcw_pkg::DIV_RATIO;
                        o_cmd.div_start = !i_status.short_zero;
                        n_div_go        = !i_status.short_zero;
                        n_state         = dbcw_pkg::S_RATIO_DIV;
                    end
                end
            end
            dbcw_pkg::S_RATIO_DIV: begin
                o_cmd.div_sel = dbcw_pkg::DIV_RATIO;
                if (!i_status.div_busy && !r_div_go) begin
                    o_cmd.div_sel   = dbcw_pkg::DIV_STEP;
                    o_cmd.div_start = 1'b1;
                    n_div_go        = 1'b1;
                    n_state         = dbcw_pkg::S_STEP_DIV;
                end
            end
            dbcw_pkg::S_STEP_DIV: begin
                o_cmd.div_sel = dbcw_pkg::DIV_STEP;
                if (!i_status.div_busy && !r_div_go) begin
                    n_state = dbcw_pkg::S_WINDOW;
                end
            end
            dbcw_pkg::S_WINDOW: begin
                o_cmd.do_window = 1'b1;
                n_state         = dbcw_pkg::S_OUT;
            end
            dbcw_pkg::S_OUT: begin
                o_cmd.do_out = 1'b1;
                n_state      = dbcw_pkg::S_HOLD;
            end
            dbcw_pkg::S_HOLD: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = dbcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dbcw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/dbcw_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbcw_dp
// Datapath: configuration, state registers, arithmetic and result register.
// ----------------------------------------------------------------------------
module dbcw_dp #(
    parameter int unsigned TIMEOUT_MULT         = dbcw_pkg::TIMEOUT_MULT_DEF,
    parameter int unsigned PROCESS_DELAY_US     = dbcw_pkg::PROCESS_DELAY_US_DEF,
    parameter int unsigned IDLE_TIMEOUT_STEP_US = dbcw_pkg::IDLE_TIMEOUT_STEP_US_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_mode,
    input  wire logic [31:0]        i_ack_seq,
    input  wire logic               i_ack_known,
    input  wire logic [31:0]        i_rtt_sample_us,
    input  wire logic [15:0]        i_loss_count,
    input  wire logic [15:0]        i_total_count,
    input  wire logic               i_has_outstanding_data,
    input  wire dbcw_pkg::t_cmd     i_cmd,
    output dbcw_pkg::t_status       o_status,
    output logic [1:0]              o_event_status,
    output logic [31:0]             o_window_out,
    output logic                    o_slow_start_out,
    output logic [31:0]             o_short_rtt_out,
    output logic [31:0]             o_long_rtt_out,
    output logic [16:0]             o_loss_ratio_out,
    output logic [39:0]             o_next_timeout_us,
    output logic                    o_window_overflow
);

    localparam logic [4:0]  MULT_W  = 5'(TIMEOUT_MULT);
    localparam logic [19:0] PDELAY  = 20'(PROCESS_DELAY_US);
    localparam logic [26:0] ISTEP   = 27'(IDLE_TIMEOUT_STEP_US);

    logic [15:0] r_sm_long, r_sm_short;
    logic [17:0] r_alpha, r_beta;
    logic [31:0] r_incr, r_base, r_ssth, r_maxw;

    logic [31:0] r_window;
    logic        r_ss;
    logic [31:0] r_long, r_short;
    logic [16:0] r_loss;
    logic [15:0] r_tocnt;
    logic [31:0] r_oldest;

    logic        r_mode, r_known, r_outst;
    logic [31:0] r_seq, r_sample;
    logic [15:0] r_lcnt, r_tcnt;
    logic [47:0] r_ratio;
    logic [1:0]  r_status;
    logic [39:0] r_next;
    logic        r_ovf;

    logic [1:0]  r_ev;
    logic [31:0] r_win_o, r_short_o, r_long_o;
    logic        r_ss_o;
    logic [16:0] r_loss_o;
    logic [39:0] r_next_o;
    logic        r_ovf_o;

    // flags carried between steps of one event
    logic r_long_seeded;
    logic r_loss_pend;
    logic r_ratio_pend;

    logic [47:0] div_num;
    logic [31:0] div_den;
    logic [47:0] div_q;
    logic        div_busy;
    logic [15:0] sm_w;
    logic [31:0] sm_avg;
    logic [16:0] sm_inv;
    logic [49:0] sm_acc;
    logic [31:0] seq_nx;
    logic [15:0] to_inc;
    logic [37:0] to_per;
    logic [56:0] to_busy_prod;
    logic [43:0] to_idle_prod;
    logic [36:0] re_arm;
    logic [33:0] w_ss;
    logic [32:0] step;
    logic signed [18:0] delta;
    logic [33:0] w_av;
    logic [33:0] w_cl;
    logic [16:0] loss_sat;

    dbcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    always_comb begin
        div_num = {16'd0, r_lcnt, 16'd0} + {33'd0, r_tcnt[15:1]};
        div_den = {16'd0, r_tcnt};
        case (i_cmd.div_sel)
            dbcw_pkg::DIV_RATIO: begin
                div_num = {r_long, 16'd0};
                div_den = r_short;
            end
            dbcw_pkg::DIV_STEP: begin
                div_num = {r_incr, 16'd0};
                div_den = r_window;
            end
            default: begin
            end
        endcase
    end

    // smoothing: one weighted sum per cycle, shared by both averages
    always_comb begin
        sm_w   = i_cmd.smooth_short ? r_sm_short : r_sm_long;
        sm_avg = i_cmd.smooth_short ? r_short : r_long;
        sm_inv = 17'h10000 - {1'b0, sm_w};
        sm_acc = ({33'd0, sm_inv} * {18'd0, sm_avg}) + ({34'd0, sm_w} * {18'd0, r_sample})
                 + 50'd32768;
    end

    assign seq_nx   = r_seq + 32'd1;
    assign to_inc   = (r_tocnt != 16'hFFFF) ? r_tocnt + 16'd1 : r_tocnt;
    assign to_per   = 38'(PDELAY) + 38'(MULT_W) * 38'(r_long);
    assign to_busy_prod = 57'(to_inc) * 57'(to_per);
    assign to_idle_prod = 44'(17'(to_inc) + 17'd1) * 44'(ISTEP);
    assign re_arm   = 37'(MULT_W) * 37'(r_short);
    assign loss_sat = (div_q > 48'h10000) ? 17'h10000 : div_q[16:0];

    always_comb begin
        w_ss  = {2'b0, r_window} + 34'h10000;
        step  = (r_window == '0) ? 33'hFFFFFFFF : {1'b0, div_q[31:0]} |
                {|div_q[47:32], 32'd0};
        step  = (|div_q[47:32] && r_window != '0) ? 33'h1_0000_0000 | 33'(div_q[31:0])
                : step;
        delta = 19'sh10000 - $signed({1'b0, r_ratio[17:0]});
        w_av  = {2'b0, r_window};
        if (r_short != '0) begin
            if (|r_ratio[47:18] || delta < $signed({r_alpha[17], r_alpha})) begin
                if (|r_ratio[47:18]) begin
                    w_av = {2'b0, r_window} + {1'b0, step};
                end else begin
                    w_av = {2'b0, r_window} + {1'b0, step};
                end
            end else if (delta > $signed({r_beta[17], r_beta})) begin
                w_av = ({1'b0, step} >= {2'b0, r_window}) ? 34'd0
                       : {2'b0, r_window} - {1'b0, step};
            end
        end
        if (w_av < {2'b0, r_base}) begin
            w_av = {2'b0, r_base};
        end
        w_cl = r_ss ? w_ss : w_av;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_long  <= 16'd6554;
            r_sm_short <= 16'd32768;
            r_alpha    <= 18'd3277;
            r_beta     <= 18'd13107;
            r_incr     <= 32'd65536;
            r_base     <= 32'd65536;
            r_ssth     <= 32'd4194304;
            r_maxw     <= 32'd67108864;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dbcw_pkg::CFG_SMOOTH_LONG:  r_sm_long  <= i_cfg_data[15:0];
                dbcw_pkg::CFG_SMOOTH_SHORT: r_sm_short <= i_cfg_data[15:0];
                dbcw_pkg::CFG_ALPHA:        r_alpha    <= i_cfg_data[17:0];
                dbcw_pkg::CFG_BETA:         r_beta     <= i_cfg_data[17:0];
                dbcw_pkg::CFG_INCREMENT:    r_incr     <= i_cfg_data;
                dbcw_pkg::CFG_BASE:         r_base     <= i_cfg_data;
                dbcw_pkg::CFG_SS_THRESH:    r_ssth     <= i_cfg_data;
                dbcw_pkg::CFG_MAX_WINDOW:   r_maxw     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 32'd65536;
            r_ss     <= 1'b1;
            r_long   <= '0;
            r_short  <= '0;
            r_loss   <= '0;
            r_tocnt  <= '0;
            r_oldest <= '0;
            r_status <= dbcw_pkg::ST_APPLIED;
            r_next   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cmd.do_timeout) begin
                r_status <= dbcw_pkg::ST_TIMEOUT;
                r_ss     <= 1'b1;
                r_window <= r_base;
                r_tocnt  <= to_inc;
                r_ovf    <= 1'b0;
                if (r_outst) begin
                    r_next <= |to_busy_prod[56:40] ? dbcw_pkg::MAX40 : to_busy_prod[39:0];
                end else begin
                    r_next <= |to_idle_prod[43:40] ? dbcw_pkg::MAX40 : to_idle_prod[39:0];
                end
            end
            if (i_cmd.do_drop) begin
                r_status <= dbcw_pkg::ST_OUTDATED;
                r_next   <= '0;
                r_ovf    <= 1'b0;
            end
            if (i_cmd.do_unknown) begin
                r_status <= dbcw_pkg::ST_UNKNOWN;
                r_next   <= '0;
                r_ovf    <= 1'b0;
                if (seq_nx > r_oldest) begin
                    r_oldest <= seq_nx;
                end
            end
            if (i_cmd.smooth_long) begin
                if (r_long != '0) begin
                    r_long <= sm_acc[47:16];
                end else begin
                    r_long  <= r_sample;
                    r_short <= r_sample;
                end
            end
            if (i_cmd.smooth_short && r_long_seeded) begin
                r_short <= sm_acc[47:16];
            end
            if (!div_busy && r_loss_pend) begin
                r_loss <= loss_sat;
            end
            if (i_cmd.do_window) begin
                r_status <= dbcw_pkg::ST_APPLIED;
                if (r_ss && w_ss > {2'b0, r_ssth}) begin
                    r_ss <= 1'b0;
                end
                if (w_cl > {2'b0, r_maxw}) begin
                    r_window <= r_maxw;
                    r_ovf    <= 1'b1;
                end else begin
                    r_window <= w_cl[31:0];
                    r_ovf    <= 1'b0;
                end
                if (seq_nx > r_oldest) begin
                    r_oldest <= seq_nx;
                end
                r_next  <= r_outst ? 40'(re_arm) : 40'd0;
                r_tocnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_seeded <= 1'b0;
            r_loss_pend   <= 1'b0;
            r_ratio_pend  <= 1'b0;
        end else begin
            if (i_cmd.smooth_long) begin
                r_long_seeded <= (r_long != '0);
            end
            if (i_cmd.div_start) begin
                r_loss_pend  <= (i_cmd.div_sel == dbcw_pkg::DIV_LOSS);
                r_ratio_pend <= (i_cmd.div_sel == dbcw_pkg::DIV_RATIO);
            end else if (!div_busy) begin
                r_loss_pend  <= 1'b0;
                r_ratio_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_seq    <= i_ack_seq;
            r_known  <= i_ack_known;
            r_sample <= i_rtt_sample_us;
            r_lcnt   <= i_loss_count;
            r_tcnt   <= i_total_count;
            r_outst  <= i_has_outstanding_data;
            r_ratio  <= '0;
        end else if (!div_busy && r_ratio_pend) begin
            r_ratio <= div_q;
        end
        if (i_cmd.do_out) begin
            r_ev      <= r_status;
            r_win_o   <= r_window;
            r_ss_o    <= r_ss;
            r_short_o <= r_short;
            r_long_o  <= r_long;
            r_loss_o  <= r_loss;
            r_next_o  <= r_next;
            r_ovf_o   <= r_ovf;
        end
    end

    assign o_status.is_timeout = r_mode;
    assign o_status.is_old     = r_seq < r_oldest;
    assign o_status.is_known   = r_known;
    assign o_status.div_busy   = div_busy;
    assign o_status.total_zero = (r_tcnt == '0);
    assign o_status.slow_start = r_ss;
    assign o_status.short_zero = (r_short == '0);

    assign o_event_status    = r_ev;
    assign o_window_out      = r_win_o;
    assign o_slow_start_out  = r_ss_o;
    assign o_short_rtt_out   = r_short_o;
    assign o_long_rtt_out    = r_long_o;
    assign o_loss_ratio_out  = r_loss_o;
    assign o_next_timeout_us = r_next_o;
    assign o_window_overflow = r_ovf_o;

endmodule

`default_nettype wire

// ----- src/delay_based_congestion_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A timeout, dropped or unknown ACK goes from the timeout check to the result register.
// A known ACK runs smoothing and up to three divisions (loss; in avoidance also ratio
// and step) in the one-bit-per-cycle divider, then the window update.
// One event at a time; the next transfer is taken once the result is taken.
// Reset is synchronous, active low; it restores config, state and control registers only.
// ----------------------------------------------------------------------------
// delay_based_congestion_window
// Delay-based congestion window controller for ACK and timeout events.
// ----------------------------------------------------------------------------
module delay_based_congestion_window #(
    parameter int unsigned TIMEOUT_MULT         = dbcw_pkg::TIMEOUT_MULT_DEF,
    parameter int unsigned PROCESS_DELAY_US     = dbcw_pkg::PROCESS_DELAY_US_DEF,
    parameter int unsigned IDLE_TIMEOUT_STEP_US = dbcw_pkg::IDLE_TIMEOUT_STEP_US_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_ack_seq,
    input  wire logic        i_ack_known,
    input  wire logic [31:0] i_rtt_sample_us,
    input  wire logic [15:0] i_loss_count,
    input  wire logic [15:0] i_total_count,
    input  wire logic        i_has_outstanding_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_status,
    output logic [31:0]      o_window_out,
    output logic             o_slow_start_out,
    output logic [31:0]      o_short_rtt_out,
    output logic [31:0]      o_long_rtt_out,
    output logic [16:0]      o_loss_ratio_out,
    output logic [39:0]      o_next_timeout_us,
    output logic             o_window_overflow
);

    dbcw_pkg::t_cmd    cmd;
    dbcw_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    dbcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dbcw_dp #(
        .TIMEOUT_MULT         (TIMEOUT_MULT),
        .PROCESS_DELAY_US     (PROCESS_DELAY_US),
        .IDLE_TIMEOUT_STEP_US (IDLE_TIMEOUT_STEP_US)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_mode                 (i_mode),
        .i_ack_seq              (i_ack_seq),
        .i_ack_known            (i_ack_known),
        .i_rtt_sample_us        (i_rtt_sample_us),
        .i_loss_count           (i_loss_count),
        .i_total_count          (i_total_count),
        .i_has_outstanding_data (i_has_outstanding_data),
        .i_cmd                  (cmd),
        .o_status               (status),
        .o_event_status         (o_event_status),
        .o_window_out           (o_window_out),
        .o_slow_start_out       (o_slow_start_out),
        .o_short_rtt_out        (o_short_rtt_out),
        .o_long_rtt_out         (o_long_rtt_out),
        .o_loss_ratio_out       (o_loss_ratio_out),
        .o_next_timeout_us      (o_next_timeout_us),
        .o_window_overflow      (o_window_overflow)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("transfer accepted while result pending");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_window_out))
        else $error("stalled result changed");
    a_window_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_window_overflow |-> o_event_status == dbcw_pkg::ST_APPLIED)
        else $error("overflow on non-applied event");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Event-level check of the congestion window controller: ACK and timeout
// transfers are driven with random gaps, each result is compared field by
// field against a cycle-free prediction of status, window, RTT, loss and timeout state.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic        mode;
        logic [31:0] seq;
        logic        known;
        logic [31:0] rtt;
        logic [15:0] loss;
        logic [15:0] total;
        logic        outst;
    } t_event;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] window;
        logic        slow;
        logic [31:0] short_rtt;
        logic [31:0] long_rtt;
        logic [16:0] loss_ratio;
        logic [39:0] next_to;
        logic        ovf;
    } t_update;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        i_mode = 1'b0;
    logic [31:0] i_ack_seq = '0;
    logic        i_ack_known = 1'b0;
    logic [31:0] i_rtt_sample_us = '0;
    logic [15:0] i_loss_count = '0;
    logic [15:0] i_total_count = '0;
    logic        i_has_outstanding_data = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_cfg_ready, o_stall, o_valid, o_slow_start_out, o_window_overflow;
    logic [1:0]  o_event_status;
    logic [31:0] o_window_out, o_short_rtt_out, o_long_rtt_out;
    logic [16:0] o_loss_ratio_out;
    logic [39:0] o_next_timeout_us;

    delay_based_congestion_window i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state and configuration
    logic [15:0] w_long, w_short;
    logic [17:0] alpha, beta;
    logic [31:0] incr, base_win, ss_thresh, max_win;
    logic [31:0] cwnd, long_avg, short_avg, oldest;
    logic        in_slow;
    logic [16:0] loss_r;
    logic [15:0] to_count;

    t_event  pending_events[$];
    t_update expected_updates[$];
    int      mismatches = 0;
    bit      in_taken = 1'b0;
    bit      gaps_on = 1'b1;
    bit      hold_off = 1'b0;

    function automatic logic [31:0] ewma(logic [31:0] avg, logic [31:0] s, logic [15:0] w);
        logic [63:0] acc;
        acc = (64'd65536 - w) * avg + 64'(w) * s + 64'd32768;
        return acc[47:16];
    endfunction

    function automatic logic [39:0] clip40(logic [63:0] v);
        return v > 64'(dbcw_pkg::MAX40) ? dbcw_pkg::MAX40 : v[39:0];
    endfunction

    task automatic predict_event(input t_event e);
        t_update u;
        logic [63:0] w, ratio, step, r;
        longint delta;
        logic [31:0] nx;
        u.next_to = '0;
        u.ovf = 1'b0;
        nx = e.seq + 32'd1;
        if (e.mode) begin
            u.status = dbcw_pkg::ST_TIMEOUT;
            in_slow = 1'b1;
            cwnd = base_win;
            if (to_count != 16'hFFFF) to_count++;
            if (e.outst)
                u.next_to = clip40(64'(to_count) * (64'(dbcw_pkg::PROCESS_DELAY_US_DEF)
                            + 64'(dbcw_pkg::TIMEOUT_MULT_DEF) * long_avg));
            else
                u.next_to = clip40((64'd1 + to_count)
                            * 64'(dbcw_pkg::IDLE_TIMEOUT_STEP_US_DEF));
        end else if (e.seq < oldest) begin
            u.status = dbcw_pkg::ST_OUTDATED;
        end else if (!e.known) begin
            u.status = dbcw_pkg::ST_UNKNOWN;
            if (nx > oldest) oldest = nx;
        end else begin
            u.status = dbcw_pkg::ST_APPLIED;
            if (long_avg != 0) begin
                long_avg = ewma(long_avg, e.rtt, w_long);
                short_avg = ewma(short_avg, e.rtt, w_short);
            end else begin
                long_avg = e.rtt;
                short_avg = e.rtt;
            end
            if (e.total != 0) begin
                r = (64'(e.loss) * 64'd65536 + e.total / 2) / e.total;
                loss_r = r > 64'd65536 ? 17'd65536 : r[16:0];
            end
            w = cwnd;
            if (in_slow) begin
                w += 64'd65536;
                if (w > ss_thresh) in_slow = 1'b0;
            end else begin
                if (short_avg != 0) begin
                    ratio = (64'(long_avg) << 16) / short_avg;
                    delta = 64'sd65536 - longint'(ratio);
                    step = cwnd != 0 ? (64'(incr) << 16) / cwnd : 64'hFFFF_FFFF;
                    if (delta < longint'($signed(alpha)))
                        w += step;
                    else if (delta > longint'($signed(beta)))
                        w = step >= w ? 64'd0 : w - step;
                end
                if (w < base_win) w = base_win;
            end
            if (w > max_win) begin
                w = max_win;
                u.ovf = 1'b1;
            end
            cwnd = w[31:0];
            if (nx > oldest) oldest = nx;
            u.next_to = e.outst ? clip40(64'(dbcw_pkg::TIMEOUT_MULT_DEF) * short_avg) : '0;
            to_count = '0;
        end
        u.window = cwnd;
        u.slow = in_slow;
        u.short_rtt = short_avg;
        u.long_rtt = long_avg;
        u.loss_ratio = loss_r;
        expected_updates.push_back(u);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            dbcw_pkg::CFG_SMOOTH_LONG:  w_long = val[15:0];
            dbcw_pkg::CFG_SMOOTH_SHORT: w_short = val[15:0];
            dbcw_pkg::CFG_ALPHA:        alpha = val[17:0];
            dbcw_pkg::CFG_BETA:         beta = val[17:0];
            dbcw_pkg::CFG_INCREMENT:    incr = val;
            dbcw_pkg::CFG_BASE:         base_win = val;
            dbcw_pkg::CFG_SS_THRESH:    ss_thresh = val;
            dbcw_pkg::CFG_MAX_WINDOW:   max_win = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || i_valid || expected_updates.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_event make_event(logic m, logic [31:0] s, logic k, logic [31:0] t,
                                          logic [15:0] l, logic [15:0] tot, logic o);
        t_event e;
        e.mode = m; e.seq = s; e.known = k; e.rtt = t;
        e.loss = l; e.total = tot; e.outst = o;
        return e;
    endfunction

    function automatic t_event random_event(logic [31:0] seq_base);
        t_event e;
        int k;
        k = $urandom_range(0, 99);
        e.mode = k < 8;
        e.known = k >= 15;
        e.seq = (k >= 8 && k < 12) ? $urandom() : seq_base + $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0:       e.rtt = $urandom();
            1:       e.rtt = $urandom_range(0, 3);
            default: e.rtt = $urandom_range(1000, 200000);
        endcase
        e.loss = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 20));
        e.total = $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom());
        e.outst = 1'($urandom_range(0, 1));
        return e;
    endfunction

    task automatic random_phase(input int n, inout logic [31:0] seq);
        t_event e;
        for (int i = 0; i < n; i++) begin
            e = random_event(seq);
            if (!e.mode && e.seq >= seq) seq = e.seq + 1;
            pending_events.push_back(e);
        end
        wait_drained();
    endtask

    // driver
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                if (gaps_on && $urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(0, 15);
                    i_valid <= 1'b0;
                end else begin
                    t_event e;
                    e = pending_events.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= e.mode;
                    i_ack_seq <= e.seq;
                    i_ack_known <= e.known;
                    i_rtt_sample_us <= e.rtt;
                    i_loss_count <= e.loss;
                    i_total_count <= e.total;
                    i_has_outstanding_data <= e.outst;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            predict_event(make_event(i_mode, i_ack_seq, i_ack_known, i_rtt_sample_us,
                                     i_loss_count, i_total_count, i_has_outstanding_data));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                t_update u;
                u = expected_updates.pop_front();
                if (u.status !== o_event_status || u.window !== o_window_out
                    || u.slow !== o_slow_start_out || u.short_rtt !== o_short_rtt_out
                    || u.long_rtt !== o_long_rtt_out || u.loss_ratio !== o_loss_ratio_out
                    || u.next_to !== o_next_timeout_us || u.ovf !== o_window_overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d win=%h ss=%b srtt=%h lrtt=%h lr=%h nt=%h ov=%b",
                                 u.status, u.window, u.slow, u.short_rtt, u.long_rtt,
                                 u.loss_ratio, u.next_to, u.ovf,
                                 "\n         got st=%0d win=%h ss=%b srtt=%h lrtt=%h lr=%h nt=%h ov=%b",
                                 o_event_status, o_window_out, o_slow_start_out,
                                 o_short_rtt_out, o_long_rtt_out, o_loss_ratio_out,
                                 o_next_timeout_us, o_window_overflow);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [31:0] seq;
        w_long = 16'd6554; w_short = 16'd32768;
        alpha = 18'd3277; beta = 18'd13107;
        incr = 32'd65536; base_win = 32'd65536;
        ss_thresh = 32'd4194304; max_win = 32'd67108864;
        cwnd = base_win; in_slow = 1'b1;
        long_avg = '0; short_avg = '0; loss_r = '0; to_count = '0; oldest = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, all statuses, seeding, zero total, timeouts, wrap
        pending_events.push_back(make_event(1'b0, 32'd10, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1));
        pending_events.push_back(make_event(1'b0, 32'd5, 1'b1, 32'd100, 16'd1, 16'd2, 1'b1));
        pending_events.push_back(make_event(1'b0, 32'd20, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
                                            16'd1, 1'b1));
        pending_events.push_back(make_event(1'b0, 32'd21, 1'b1, 32'd0, 16'd0, 16'd0, 1'b0));
        pending_events.push_back(make_event(1'b1, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1));
        pending_events.push_back(make_event(1'b1, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b0));
        pending_events.push_back(make_event(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                                            16'hFFFF, 16'hFFFF, 1'b1));
        pending_events.push_back(make_event(1'b0, 32'd30, 1'b1, 32'd5000, 16'hFFFF,
                                            16'hFFFF, 1'b1));
        pending_events.push_back(make_event(1'b0, 32'hFFFF_FFFF, 1'b0, 32'd0, 16'd0,
                                            16'd0, 1'b0));
        pending_events.push_back(make_event(1'b0, 32'hFFFF_FFFF, 1'b1, 32'd1, 16'd3,
                                            16'd7, 1'b0));
        wait_drained();

        // tiny threshold and ceiling: leave slow start, saturate
        write_reg(dbcw_pkg::CFG_BASE, 32'd65536);
        write_reg(dbcw_pkg::CFG_SS_THRESH, 32'd65536);
        write_reg(dbcw_pkg::CFG_MAX_WINDOW, 32'd131072);
        write_reg(dbcw_pkg::CFG_INCREMENT, 32'hFFFF_FFFF);
        write_reg(dbcw_pkg::CFG_ALPHA, 32'h1FFFF);
        write_reg(dbcw_pkg::CFG_BETA, 32'h1FFFF);
        write_reg(dbcw_pkg::CFG_SMOOTH_LONG, 32'd0);
        write_reg(dbcw_pkg::CFG_SMOOTH_SHORT, 32'hFFFF);
        seq = 32'hFFFF_FFF0;
        random_phase(60, seq);

        // shrink path, floor at base
        write_reg(dbcw_pkg::CFG_ALPHA, 32'h20000);
        write_reg(dbcw_pkg::CFG_BETA, 32'h20000);
        write_reg(dbcw_pkg::CFG_MAX_WINDOW, 32'hFFFF_FFFF);
        write_reg(dbcw_pkg::CFG_BASE, 32'h0010_0000);
        write_reg(dbcw_pkg::CFG_INCREMENT, 32'h0100_0000);
        write_reg(dbcw_pkg::CFG_SMOOTH_LONG, 32'd1);
        write_reg(dbcw_pkg::CFG_SMOOTH_SHORT, 32'hC000);
        random_phase(60, seq);

        // reset-like settings with long receiver hold-off
        write_reg(dbcw_pkg::CFG_SMOOTH_LONG, 32'd6554);
        write_reg(dbcw_pkg::CFG_SMOOTH_SHORT, 32'd32768);
        write_reg(dbcw_pkg::CFG_ALPHA, 32'd3277);
        write_reg(dbcw_pkg::CFG_BETA, 32'd13107);
        write_reg(dbcw_pkg::CFG_INCREMENT, 32'd65536);
        write_reg(dbcw_pkg::CFG_BASE, 32'hFFFF_FFFF);
        write_reg(dbcw_pkg::CFG_BASE, 32'd65536);
        write_reg(dbcw_pkg::CFG_SS_THRESH, 32'hFFFF_FFFF);
        write_reg(dbcw_pkg::CFG_SS_THRESH, 32'd262144);
        write_reg(dbcw_pkg::CFG_MAX_WINDOW, 32'h0100_0000);
        hold_off = 1'b1;
        for (int i = 0; i < 10; i++) pending_events.push_back(random_event(seq));
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
        random_phase(250, seq);

        gaps_on = 1'b0;
        random_phase(60, seq);

        if (mismatches == 0 && expected_updates.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
